// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/pfc_pkg.sv =====
// Shared types, codes and format tables of the sample converter.
`default_nettype none

package pfc_pkg;

    localparam logic [2:0] FMT_FLOAT32 = 3'd0;
    localparam logic [2:0] FMT_INT16   = 3'd1;
    localparam logic [2:0] FMT_INT24   = 3'd2;
    localparam logic [2:0] FMT_INT32   = 3'd3;
    localparam logic [2:0] FMT_UNSUPPORTED = 3'd4;

    localparam logic DIR_TO_FLOAT = 1'b0;
    localparam logic DIR_TO_PCM   = 1'b1;

    localparam logic CFG_DIRECTION = 1'b0;
    localparam logic CFG_FORMAT    = 1'b1;

    typedef enum logic [1:0] {
        KIND_BYPASS,
        KIND_I2F,
        KIND_F2I
    } kind_t;

    typedef struct packed {
        logic        last;
        kind_t       kind;
        logic [2:0]  fmt;
        logic        sign;
        logic [31:0] data;
        logic [7:0]  exp;
        logic [23:0] mant;
    } s1_t;

    typedef struct packed {
        logic        last;
        kind_t       kind;
        logic [2:0]  fmt;
        logic        sign;
        logic [31:0] data;
        logic [4:0]  lz;
        logic [7:0]  exp;
        logic [54:0] prod;
    } s2_t;

    typedef struct packed {
        logic        last;
        kind_t       kind;
        logic [2:0]  fmt;
        logic        sign;
        logic [31:0] data;
        logic [7:0]  exp;
        logic [55:0] prod;
    } s3_t;

    typedef struct packed {
        logic        last;
        logic [31:0] data;
    } out_t;

    function automatic logic [31:0] fmt_mask(input logic [2:0] fmt);
        logic [31:0] m;
        case (fmt)
            FMT_INT16: m = 32'h0000_FFFF;
            FMT_INT24: m = 32'h00FF_FFFF;
            default:   m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic [30:0] fmt_scale(input logic [2:0] fmt);
        logic [30:0] k;
        case (fmt)
            FMT_INT16: k = 31'd32767;
            FMT_INT24: k = 31'd8388607;
            default:   k = 31'd2147483647;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] fmt_frac_bits(input logic [2:0] fmt);
        logic [4:0] f;
        case (fmt)
            FMT_INT16: f = 5'd15;
            FMT_INT24: f = 5'd23;
            default:   f = 5'd31;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

// ===== src/pfc_decode.sv =====
// First stage: sign extension, float classification and clamping.
`default_nettype none

module pfc_decode (
    input  wire logic         clk,
    input  wire logic         en,
    input  wire logic [31:0]  sample,
    input  wire logic         last,
    input  wire logic         dir,
    input  wire logic [2:0]   fmt,
    output pfc_pkg::s1_t      s1_reg
);
    import pfc_pkg::*;

    s1_t         s1_next;
    logic [31:0] sx;
    logic [31:0] mag;
    logic [31:0] kval;
    logic [7:0]  e;
    logic [22:0] fr;

    always_comb
    begin
        case (fmt)
            FMT_INT16: sx = {{16{sample[15]}}, sample[15:0]};
            FMT_INT24: sx = {{8{sample[23]}}, sample[23:0]};
            default:   sx = sample;
        endcase
        mag  = sx[31] ? (~sx + 32'd1) : sx;
        kval = {1'b0, fmt_scale(fmt)};
        e    = sample[30:23];
        fr   = sample[22:0];

        s1_next      = '0;
        s1_next.last = last;
        s1_next.fmt  = fmt;
        s1_next.kind = KIND_BYPASS;
        if (fmt == FMT_FLOAT32)
        begin
            s1_next.data = sample;
        end
        else if (fmt >= FMT_UNSUPPORTED)
        begin
            s1_next.data = '0;
        end
        else if (dir == DIR_TO_FLOAT)
        begin
            if (mag != 32'd0)
            begin
                s1_next.kind = KIND_I2F;
                s1_next.sign = sx[31];
                s1_next.data = mag;
            end
        end
        else if (e == 8'hFF && fr != 23'd0)
        begin
            s1_next.data = '0;
        end
        else if (e >= 8'd127)
        begin
            s1_next.data = (sample[31] ? (~kval + 32'd1) : kval) & fmt_mask(fmt);
        end
        else if (e != 8'd0)
        begin
            s1_next.kind = KIND_F2I;
            s1_next.sign = sample[31];
            s1_next.exp  = e;
            s1_next.mant = {1'b1, fr};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/pfc_norm_mult.sv =====
// Second stage: leading-zero normalization and scale multiplication.
`default_nettype none

module pfc_norm_mult (
    input  wire logic         clk,
    input  wire logic         en,
    input  wire pfc_pkg::s1_t s1,
    output pfc_pkg::s2_t      s2_reg
);
    import pfc_pkg::*;

    s2_t        s2_next;
    logic [4:0] lz;

    always_comb
    begin
        lz = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (s1.data[i])
            begin
                lz = 5'(31 - i);
            end
        end

        s2_next      = '0;
        s2_next.last = s1.last;
        s2_next.kind = s1.kind;
        s2_next.fmt  = s1.fmt;
        s2_next.sign = s1.sign;
        s2_next.exp  = s1.exp;
        s2_next.lz   = lz;
        s2_next.data = (s1.kind == KIND_I2F) ? (s1.data << lz) : s1.data;
        s2_next.prod = {31'd0, s1.mant} * {24'd0, fmt_scale(s1.fmt)};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg <= s2_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/pfc_round.sv =====
// Third stage: round to nearest even for both directions.
`default_nettype none

module pfc_round (
    input  wire logic         clk,
    input  wire logic         en,
    input  wire pfc_pkg::s2_t s2,
    output pfc_pkg::s3_t      s3_reg
);
    import pfc_pkg::*;

    s3_t         s3_next;
    logic        up_i;
    logic [24:0] m25;
    logic [8:0]  expb;
    logic [5:0]  drop;
    logic [55:0] p56;
    logic [55:0] lmask;
    logic [55:0] half;
    logic [55:0] rem;
    logic        up_f;

    always_comb
    begin
        up_i = (s2.data[7:0] > 8'h80) || (s2.data[7:0] == 8'h80 && s2.data[8]);
        m25  = {1'b0, s2.data[31:8]} + {24'd0, up_i};
        expb = 9'd158 - {4'd0, s2.lz} - {4'd0, fmt_frac_bits(s2.fmt)} + {8'd0, m25[24]};

        case (s2.fmt)
            FMT_INT16: drop = s2.prod[38] ? 6'd15 : 6'd14;
            FMT_INT24: drop = s2.prod[46] ? 6'd23 : 6'd22;
            default:   drop = s2.prod[54] ? 6'd2 : 6'd1;
        endcase
        p56   = {1'b0, s2.prod};
        lmask = (56'd1 << drop) - 56'd1;
        half  = 56'd1 << (drop - 6'd1);
        rem   = p56 & lmask;
        up_f  = (rem > half) || (rem == half && p56[drop]);

        s3_next      = '0;
        s3_next.last = s2.last;
        s3_next.kind = s2.kind;
        s3_next.fmt  = s2.fmt;
        s3_next.sign = s2.sign;
        s3_next.exp  = s2.exp;
        s3_next.prod = (p56 & ~lmask) + (up_f ? (56'd1 << drop) : 56'd0);
        if (s2.kind == KIND_I2F)
        begin
            s3_next.data = {s2.sign, expb[7:0], m25[24] ? 23'd0 : m25[22:0]};
        end
        else
        begin
            s3_next.data = s2.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_reg <= s3_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/pfc_finish.sv =====
// Fourth stage: integer truncation, sign and output register.
`default_nettype none

module pfc_finish (
    input  wire logic         clk,
    input  wire logic         en,
    input  wire pfc_pkg::s3_t s3,
    output pfc_pkg::out_t     out_reg
);
    import pfc_pkg::*;

    out_t        out_next;
    logic [7:0]  sh;
    logic [55:0] v;
    logic [31:0] v32;

    always_comb
    begin
        sh  = 8'd150 - s3.exp;
        v   = (sh >= 8'd56) ? 56'd0 : (s3.prod >> sh);
        v32 = v[31:0];

        out_next.last = s3.last;
        if (s3.kind == KIND_F2I)
        begin
            out_next.data = (s3.sign ? (~v32 + 32'd1) : v32) & fmt_mask(s3.fmt);
        end
        else
        begin
            out_next.data = s3.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/pcm_float_sample_converter_core.sv =====
// Four register stages; an accepted item passes through decode, norm_mult, round and finish in order.
// Throughput: one item per cycle while out_ready holds, set by the four-stage pipeline with one multiplier.
// Each stage advances when its successor is empty or advancing, so bubbles are filled.
// Reset clears all valid bits, direction to PCM-to-float and format to unsupported.
`default_nettype none

module pcm_float_sample_converter_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] sample_in,
    input  wire logic        last_in,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      sample_out,
    output logic             last_out,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data
);
    import pfc_pkg::*;

    logic       dir_reg;
    logic       dir_next;
    logic [2:0] fmt_reg;
    logic [2:0] fmt_next;
    logic       v1_reg, v2_reg, v3_reg, v4_reg;
    logic       ready1, ready2, ready3, ready4;
    s1_t        s1;
    s2_t        s2;
    s3_t        s3;
    out_t       res;

    assign cfg_ready = 1'b1;
    assign ready4    = !v4_reg || out_ready;
    assign ready3    = !v3_reg || ready4;
    assign ready2    = !v2_reg || ready3;
    assign ready1    = !v1_reg || ready2;
    assign in_ready  = ready1;

    always_comb
    begin
        dir_next = dir_reg;
        fmt_next = fmt_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_DIRECTION: dir_next = cfg_data[0];
                CFG_FORMAT:    fmt_next = cfg_data[2:0];
                default:       dir_next = dir_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg <= DIR_TO_FLOAT;
            fmt_reg <= FMT_UNSUPPORTED;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
        end
        else
        begin
            dir_reg <= dir_next;
            fmt_reg <= fmt_next;
            if (ready1) v1_reg <= in_valid;
            if (ready2) v2_reg <= v1_reg;
            if (ready3) v3_reg <= v2_reg;
            if (ready4) v4_reg <= v3_reg;
        end
    end

    pfc_decode u_decode (
        .clk    (clk),
        .en     (ready1),
        .sample (sample_in),
        .last   (last_in),
        .dir    (dir_reg),
        .fmt    (fmt_reg),
        .s1_reg (s1)
    );

    pfc_norm_mult u_norm_mult (
        .clk    (clk),
        .en     (ready2),
        .s1     (s1),
        .s2_reg (s2)
    );

    pfc_round u_round (
        .clk    (clk),
        .en     (ready3),
        .s2     (s2),
        .s3_reg (s3)
    );

    pfc_finish u_finish (
        .clk     (clk),
        .en      (ready4),
        .s3      (s3),
        .out_reg (res)
    );

    assign out_valid  = v4_reg;
    assign sample_out = res.data;
    assign last_out   = res.last;

endmodule

`default_nettype wire

// ===== src/pfc_checker.sv =====
// Port-level checker for the sample converter and its bind.
`default_nettype none
`include "assert_macros.svh"

module pfc_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready
);

    `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "Output item dropped while stalled.")
    `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |-> !out_valid, "Output valid during reset.")
    `ASSERT_CLK(a_ready_flow, clk, rst_n, out_ready |-> in_ready, "Input stalled while output drains.")
    `ASSERT_CLK(a_latency, clk, rst_n, (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid, "Item did not reach the output in time.")

endmodule

bind pcm_float_sample_converter_core pfc_checker u_pfc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready)
);

`default_nettype wire
